// ===== rtl/core/mrpt_pkg.sv =====
// mrpt_pkg: shared constants, witness tables and controller/datapath interface structs
// for the miller-rabin prime test block. no dependencies.
package mrpt_pkg;

    localparam int NUMBER_BITS_DEF = 63;
    localparam int CAND_W          = 63;
    localparam int BASE_W          = 31;
    localparam logic [63:0] SMALL_LIMIT = 64'd4759123141;

    localparam logic [2:0] SMALL_LAST = 3'd2;
    localparam logic [2:0] LARGE_LAST = 3'd6;

    // witness bases for the small and the large range
    function automatic logic [BASE_W-1:0] base_of(input logic is_large, input logic [2:0] idx);
        logic [BASE_W-1:0] b;
        b = '0;
        if (!is_large) begin
            case (idx)
                3'd0:    b = 31'd2;
                3'd1:    b = 31'd7;
                3'd2:    b = 31'd61;
                default: b = 31'd2;
            endcase
        end else begin
            case (idx)
                3'd0:    b = 31'd2;
                3'd1:    b = 31'd325;
                3'd2:    b = 31'd9375;
                3'd3:    b = 31'd28178;
                3'd4:    b = 31'd450775;
                3'd5:    b = 31'd9780504;
                3'd6:    b = 31'd1795265022;
                default: b = 31'd2;
            endcase
        end
        return b;
    endfunction

    typedef struct packed {
        logic load;
        logic pre_step;
        logic next_round;
        logic exp_init;
        logic mul_start;
        logic mul_sel_base;
        logic ebit_next;
        logic sq_init;
        logic sq_next;
    } t_cmd;

    typedef struct packed {
        logic pre_last;
        logic trivial;
        logic trivial_prime;
        logic base_ge_n;
        logic last_round;
        logic ebit;
        logic exp_last;
        logic x_one;
        logic x_nm1;
        logic sq_more;
        logic mul_done;
        logic mul_busy;
    } t_status;

endpackage

// ===== rtl/core/mrpt_mulmod.sv =====
// mrpt_mulmod: bit-serial modular multiplier, one multiplier bit per cycle (double, add, reduce)
// depends on mrpt_pkg
module mrpt_mulmod
    import mrpt_pkg::*;
#(
    parameter int NB = NUMBER_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NB-1:0] i_a,
    input  logic [NB-1:0] i_b,
    input  logic [NB-1:0] i_m,
    output logic          o_busy,
    output logic          o_done,
    output logic [NB-1:0] o_p
);
    localparam int CW = $clog2(NB + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NB-1:0] r_acc, r_a, r_b;
    logic [NB:0]   dbl, dbl_red, sum;
    logic [NB-1:0] n_acc;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        sum     = dbl_red + {1'b0, r_a};
        if (r_b[NB-1]) begin
            n_acc = (sum >= {1'b0, i_m}) ? sum[NB-1:0] - i_m : sum[NB-1:0];
        end else begin
            n_acc = dbl_red[NB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_cnt <= CW'(NB - 1);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[NB-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// ===== rtl/core/mrpt_datapath.sv =====
// mrpt_datapath: candidate, odd part, exponent scan, round index and witness value registers
// depends on mrpt_pkg and mrpt_mulmod
module mrpt_datapath
    import mrpt_pkg::*;
#(
    parameter int NB = NUMBER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CAND_W-1:0] i_candidate,
    input  t_cmd              i_cmd,
    output t_status           o_st
);
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_n, r_sh, r_d, r_e, r_x;
    logic [CW-1:0] r_s, r_k, r_pcnt, r_ecnt;
    logic [1:0]    r_m3, n_m3;
    logic [2:0]    r_bi;
    logic          r_large;

    logic [BASE_W-1:0] base;
    logic [NB-1:0]     one_n, nm1, mul_b, prod;
    logic [63:0]       n_ext;
    logic              mul_done, mul_busy;

    assign one_n = {{(NB-1){1'b0}}, 1'b1};
    assign nm1   = r_n - one_n;
    assign n_ext = {{(64-NB){1'b0}}, r_n};
    assign base  = base_of(r_large, r_bi);
    assign mul_b = i_cmd.mul_sel_base ? NB'(base) : r_x;

    // running remainder of the scanned prefix modulo three
    always_comb begin
        case ({r_m3, r_sh[NB-1]})
            3'd0:    n_m3 = 2'd0;
            3'd1:    n_m3 = 2'd1;
            3'd2:    n_m3 = 2'd2;
            3'd3:    n_m3 = 2'd0;
            3'd4:    n_m3 = 2'd1;
            3'd5:    n_m3 = 2'd2;
            default: n_m3 = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= i_candidate[NB-1:0];
            r_sh   <= i_candidate[NB-1:0];
            r_d    <= i_candidate[NB-1:0] - one_n;
            r_s    <= '0;
            r_m3   <= '0;
            r_pcnt <= CW'(NB - 1);
        end else if (i_cmd.pre_step) begin
            r_m3   <= n_m3;
            r_sh   <= {r_sh[NB-2:0], 1'b0};
            r_pcnt <= r_pcnt - 1'b1;
            if (!r_d[0] && r_d != '0) begin
                r_d <= {1'b0, r_d[NB-1:1]};
                r_s <= r_s + 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_bi    <= '0;
            r_large <= 1'b0;
        end else if (i_cmd.pre_step) begin
            r_large <= (n_ext >= SMALL_LIMIT);
        end else if (i_cmd.next_round) begin
            r_bi <= r_bi + 1'b1;
        end
        if (i_cmd.exp_init) begin
            r_e    <= r_d;
            r_ecnt <= CW'(NB - 1);
            r_x    <= one_n;
        end else begin
            if (i_cmd.ebit_next) begin
                r_e    <= {r_e[NB-2:0], 1'b0};
                r_ecnt <= r_ecnt - 1'b1;
            end
            if (mul_done) begin
                r_x <= prod;
            end
        end
        if (i_cmd.sq_init) begin
            r_k <= CW'(1);
        end else if (i_cmd.sq_next) begin
            r_k <= r_k + 1'b1;
        end
    end

    mrpt_mulmod #(.NB(NB)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (r_x),
        .i_b     (mul_b),
        .i_m     (r_n),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_p     (prod)
    );

    always_comb begin
        o_st.pre_last      = (r_pcnt == '0);
        o_st.trivial       = (n_ext < 64'd4) || !r_n[0] || (r_m3 == 2'd0);
        o_st.trivial_prime = (n_ext == 64'd2) || (n_ext == 64'd3);
        o_st.base_ge_n     = ({{(64-BASE_W){1'b0}}, base} >= n_ext);
        o_st.last_round    = r_large ? (r_bi == LARGE_LAST) : (r_bi == SMALL_LAST);
        o_st.ebit          = r_e[NB-1];
        o_st.exp_last      = (r_ecnt == '0);
        o_st.x_one         = (r_x == one_n);
        o_st.x_nm1         = (r_x == nm1);
        o_st.sq_more       = (r_k < r_s);
        o_st.mul_done      = mul_done;
        o_st.mul_busy      = mul_busy;
    end

endmodule

// ===== rtl/core/mrpt_ctrl.sv =====
// mrpt_ctrl: sequencer for the screening pass, witness rounds and result beat
// depends on mrpt_pkg
module mrpt_ctrl
    import mrpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output logic    o_flag,
    output t_cmd    o_cmd,
    input  t_status i_st
);
    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_PRE  = 12'b000000000010,
        S_DEC  = 12'b000000000100,
        S_BASE = 12'b000000001000,
        S_EXP  = 12'b000000010000,
        S_EXW1 = 12'b000000100000,
        S_EXB  = 12'b000001000000,
        S_EXW2 = 12'b000010000000,
        S_CHK  = 12'b000100000000,
        S_SQ   = 12'b001000000000,
        S_SQW  = 12'b010000000000,
        S_DONE = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_verdict, n_verdict;
    logic   r_ovalid, r_flag;
    logic   accept, out_free;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state   = r_state;
        n_verdict = r_verdict;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PRE;
                end
            end
            S_PRE: begin
                o_cmd.pre_step = 1'b1;
                if (i_st.pre_last) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_st.trivial) begin
                    n_verdict = i_st.trivial_prime;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                if (i_st.base_ge_n) begin
                    if (i_st.last_round) begin
                        n_verdict = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        o_cmd.next_round = 1'b1;
                    end
                end else begin
                    o_cmd.exp_init = 1'b1;
                    n_state        = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_EXW1;
            end
            S_EXW1: begin
                if (i_st.mul_done) n_state = S_EXB;
            end
            S_EXB: begin
                if (i_st.ebit) begin
                    o_cmd.mul_start    = 1'b1;
                    o_cmd.mul_sel_base = 1'b1;
                    n_state            = S_EXW2;
                end else begin
                    o_cmd.ebit_next = 1'b1;
                    n_state         = i_st.exp_last ? S_CHK : S_EXP;
                end
            end
            S_EXW2: begin
                if (i_st.mul_done) begin
                    o_cmd.ebit_next = 1'b1;
                    n_state         = i_st.exp_last ? S_CHK : S_EXP;
                end
            end
            S_CHK, S_SQ: begin
                // round passes on x == 1 right after the power, or on x == n-1
                if (i_st.x_nm1 || (r_state == S_CHK && i_st.x_one)) begin
                    if (i_st.last_round) begin
                        n_verdict = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        o_cmd.next_round = 1'b1;
                        n_state          = S_BASE;
                    end
                end else if (r_state == S_CHK) begin
                    o_cmd.sq_init = 1'b1;
                    n_state       = S_SQ;
                end else if (i_st.sq_more) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.sq_next   = 1'b1;
                    n_state         = S_SQW;
                end else begin
                    n_verdict = 1'b0;
                    n_state   = S_DONE;
                end
            end
            S_SQW: begin
                if (i_st.mul_done) n_state = S_SQ;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        if (r_state == S_DONE && out_free) r_flag <= r_verdict;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_flag  = r_flag;

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_PRE))
        else $error("accepted beat did not start the screening pass");

    a_result_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> o_valid)
        else $error("finished verdict not presented");

    a_mul_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_start |-> !i_st.mul_busy)
        else $error("multiplier started while busy");

endmodule

// ===== rtl/core/miller_rabin_prime_test.sv =====
// miller_rabin_prime_test: deterministic miller-rabin test, 63-bit candidates, one at a time.
// sequence: a screening pass, then per witness a square-and-multiply scan of the exponent
// and the squarings after it, all on the one bit-serial modular multiplier.
// intake: one candidate is worked on at a time; the next is taken while a verdict waits.
// reset: synchronous active-low, clears controller state, output valid and multiplier busy/done only.
// depends on mrpt_pkg, mrpt_ctrl, mrpt_datapath
module miller_rabin_prime_test
    import mrpt_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CAND_W-1:0] i_candidate,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_is_prime_flag
);
    t_cmd    cmd;
    t_status st;

    mrpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_flag  (o_is_prime_flag),
        .o_cmd   (cmd),
        .i_st    (st)
    );

    mrpt_datapath #(.NB(NUMBER_BITS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_candidate (i_candidate),
        .i_cmd       (cmd),
        .o_st        (st)
    );

endmodule
